@@ rtl/hmfn_pkg.sv @@
// ----------------------------------------------------------------------------
// hmfn_pkg
// Shared types and constants for the heightmap face normal block.
// ----------------------------------------------------------------------------
package hmfn_pkg;

   typedef struct packed {
      logic [15:0] z00;
      logic [15:0] z10;
      logic [15:0] z01;
      logic [15:0] z11;
      logic [15:0] spacing;
      logic [7:0]  col;
      logic [11:0] row;
   } job_type;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic [14:0]        nz;
      logic [7:0]         col;
      logic [11:0]        row;
      logic               upper;
   } result_type;

   localparam logic [0:0] REG_GRID_SPACING = 1'b0;
   localparam logic [0:0] REG_ROW_LENGTH   = 1'b1;

   localparam logic [15:0] SPACING_RESET    = 16'd655;
   localparam logic [8:0]  ROW_LENGTH_RESET = 9'd201;

endpackage

@@ rtl/heightmap_face_normals.sv @@
// ----------------------------------------------------------------------------
// heightmap_face_normals
// Heights in raster order in, two unit face normals per grid cell out.
// ----------------------------------------------------------------------------
// A sample that closes no cell (first row, first column) yields no job.
// A sample that closes a cell yields the lower-right and then the
// upper-left normal; the pace is set by the normal unit, which runs for
// each of the three components a one-bit-per-cycle divide and a square
// root on a single shared datapath. A two-entry job queue holds the cell
// in work and one more, the intake stage holds one further cell, and
// intake keeps going while a result waits to be popped.
module heightmap_face_normals #(
   parameter int MAX_ROW_LENGTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [15:0]        req_height,
   input  logic               req_frame_start,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic [14:0]        rsp_normal_z,
   output logic [7:0]         rsp_cell_column,
   output logic [11:0]        rsp_cell_row,
   output logic               rsp_upper_triangle,
   output logic               rsp_last_of_run,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [15:0]        csr_data
);

   logic [15:0]          grid_spacing_ff;
   logic [8:0]           row_length_ff;
   logic                 fj_valid, fj_ready;
   hmfn_pkg::job_type    fj;
   logic                 bj_valid, bj_pop;
   hmfn_pkg::job_type    bj;
   logic                 out_valid;
   hmfn_pkg::result_type out_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_spacing_ff <= hmfn_pkg::SPACING_RESET;
         row_length_ff   <= hmfn_pkg::ROW_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == hmfn_pkg::REG_GRID_SPACING) begin
            grid_spacing_ff <= csr_data;
         end
         if (csr_index == hmfn_pkg::REG_ROW_LENGTH) begin
            row_length_ff <= csr_data[8:0];
         end
      end
   end

   hmfn_front #(
      .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .full         (req_full),
      .height       (req_height),
      .frame_start  (req_frame_start),
      .grid_spacing (grid_spacing_ff),
      .row_length   (row_length_ff),
      .job_valid    (fj_valid),
      .job_ready    (fj_ready),
      .job          (fj)
   );

   hmfn_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fj_valid),
      .ready    (fj_ready),
      .push_job (fj),
      .valid    (bj_valid),
      .pop      (bj_pop),
      .pop_job  (bj)
   );

   hmfn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (bj_valid),
      .job       (bj),
      .job_pop   (bj_pop),
      .out_valid (out_valid),
      .out_pop   (rsp_pop),
      .out_data  (out_data)
   );

   assign rsp_empty          = !out_valid;
   assign rsp_normal_x       = out_data.nx;
   assign rsp_normal_y       = out_data.ny;
   assign rsp_normal_z       = out_data.nz;
   assign rsp_cell_column    = out_data.col;
   assign rsp_cell_row       = out_data.row;
   assign rsp_upper_triangle = out_data.upper;
   assign rsp_last_of_run    = out_data.upper;

   a_pop_has_job: assert property (@(posedge clock) disable iff (reset)
      bj_pop |-> bj_valid)
      else $error("normal unit released a job the queue did not hold");

   a_blocked_stage_stalls_intake: assert property (@(posedge clock) disable iff (reset)
      (fj_valid && !fj_ready) |-> req_full)
      else $error("intake open while its job stage is blocked");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result present right after reset");

endmodule

@@ rtl/hmfn_front.sv @@
// ----------------------------------------------------------------------------
// hmfn_front
// Sample intake: row and column tracking, line buffer, cell job assembly.
// ----------------------------------------------------------------------------
module hmfn_front #(
   parameter int MAX_ROW_LENGTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [15:0]      height,
   input  logic             frame_start,
   input  logic [15:0]      grid_spacing,
   input  logic [8:0]       row_length,
   output logic             job_valid,
   input  logic             job_ready,
   output hmfn_pkg::job_type job
);

   localparam int AW = $clog2(MAX_ROW_LENGTH);
   localparam int CW = $clog2(MAX_ROW_LENGTH + 1);
   localparam int LW = (CW > 9) ? CW : 9;

   logic [15:0]       mem [MAX_ROW_LENGTH];
   logic [15:0]       rd_ff;
   logic [15:0]       left_ff;
   logic [CW-1:0]     col_ff, col_in;
   logic [11:0]       row_ff, row_in;
   logic              st_valid_ff, st_valid_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_addr_ff;
   hmfn_pkg::job_type st_job_ff;

   logic [LW-1:0]     len;
   logic [CW-1:0]     c0, col, ncol, cm1;
   logic [11:0]       r0, row, rsat;
   logic              has_cell, accept;

   assign full   = st_valid_ff && !job_ready;
   assign accept = push && !full;

   always_comb begin
      if (LW'(row_length) > LW'(MAX_ROW_LENGTH)) begin
         len = LW'(MAX_ROW_LENGTH);
      end else if (row_length < 9'd2) begin
         len = LW'(2);
      end else begin
         len = LW'(row_length);
      end
      c0 = frame_start ? '0 : col_ff;
      r0 = frame_start ? '0 : row_ff;
      if (LW'(c0) >= len) begin
         col = '0;
         row = (r0 == 12'hFFF) ? r0 : r0 + 12'd1;
      end else begin
         col = c0;
         row = r0;
      end
      rsat = (row == 12'hFFF) ? row : row + 12'd1;
      ncol = col + CW'(1);
      cm1  = col - CW'(1);
      pend_in = (LW'(ncol) == len);
      if (pend_in) begin
         col_in = '0;
         row_in = rsat;
      end else begin
         col_in = ncol;
         row_in = row;
      end
      has_cell = (col != '0) && (row != 12'd0);
      if (accept) begin
         st_valid_in = has_cell;
      end else if (job_ready) begin
         st_valid_in = 1'b0;
      end else begin
         st_valid_in = st_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[col[AW-1:0]];
         if (col != '0) begin
            mem[cm1[AW-1:0]] <= left_ff;
         end else if (pend_ff) begin
            mem[pend_addr_ff] <= left_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff           <= height;
         pend_addr_ff      <= col[AW-1:0];
         st_job_ff.z00     <= rd_ff;
         st_job_ff.z10     <= 16'd0;
         st_job_ff.z01     <= left_ff;
         st_job_ff.z11     <= height;
         st_job_ff.spacing <= (grid_spacing == 16'd0) ? 16'd1 : grid_spacing;
         st_job_ff.col     <= 8'(cm1);
         st_job_ff.row     <= row - 12'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
         pend_ff     <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         st_valid_ff <= st_valid_in;
         if (accept) begin
            pend_ff <= pend_in;
            col_ff  <= col_in;
            row_ff  <= row_in;
         end
      end
   end

   assign job_valid = st_valid_ff;

   always_comb begin
      job     = st_job_ff;
      job.z10 = rd_ff;
   end

endmodule

@@ rtl/hmfn_queue.sv @@
// ----------------------------------------------------------------------------
// hmfn_queue
// Two-entry job queue between the intake and the normal unit.
// ----------------------------------------------------------------------------
module hmfn_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              ready,
   input  hmfn_pkg::job_type push_job,
   output logic              valid,
   input  logic              pop,
   output hmfn_pkg::job_type pop_job
);

   hmfn_pkg::job_type entry_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign ready   = (count_ff != 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign do_push = push && ready;
   assign do_pop  = pop && valid;
   assign pop_job = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ff <= !wr_ff;
         end
         if (do_pop) begin
            rd_ff <= !rd_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

@@ rtl/hmfn_back.sv @@
// ----------------------------------------------------------------------------
// hmfn_back
// Normal unit: squares, then per component a bit-serial divide and a
// digit-by-digit square root, rounding, and the result register.
// ----------------------------------------------------------------------------
module hmfn_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  hmfn_pkg::job_type    job,
   output logic                 job_pop,
   output logic                 out_valid,
   input  logic                 out_pop,
   output hmfn_pkg::result_type out_data
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SQUARE = 7'b0000010,
      S_SUM    = 7'b0000100,
      S_DIV    = 7'b0001000,
      S_ROOT   = 7'b0010000,
      S_ROUND  = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic                 tri_ff, tri_in;
   logic [1:0]           k_ff, k_in;
   logic [4:0]           step_ff, step_in;
   logic [15:0]          mag_ff [3];
   logic [2:0]           neg_ff;
   logic [31:0]          sq_ff [3];
   logic [33:0]          sum_ff;
   logic [34:0]          rem_ff;
   logic [30:0]          quo_ff;
   logic [30:0]          v_ff;
   logic [31:0]          res_ff;
   logic [31:0]          bit_ff;
   logic [15:0]          comp_ff [3];
   logic                 out_valid_ff, out_valid_in;
   hmfn_pkg::result_type out_ff;

   logic [16:0] da, db;
   logic [34:0] rem_sub;
   logic        qbit;
   logic [31:0] t;
   logic        take;
   logic [16:0] rnd;
   logic [15:0] r;
   logic        out_free;

   always_comb begin
      if (tri_ff) begin
         da = {1'b0, job.z01} - {1'b0, job.z11};
         db = {1'b0, job.z00} - {1'b0, job.z01};
      end else begin
         da = {1'b0, job.z00} - {1'b0, job.z10};
         db = {1'b0, job.z10} - {1'b0, job.z11};
      end
      qbit    = rem_ff >= 35'(sum_ff);
      rem_sub = qbit ? rem_ff - 35'(sum_ff) : rem_ff;
      t       = res_ff + bit_ff;
      take    = 32'(v_ff) >= t;
      rnd     = (17'(res_ff) + 17'd1) >> 1;
      r       = rnd[15:0];
      out_free = !out_valid_ff || out_pop;
   end

   always_comb begin
      state_in     = state_ff;
      tri_in       = tri_ff;
      k_in         = k_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !out_pop;
      job_pop      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               k_in     = 2'd0;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            step_in  = 5'd0;
            state_in = S_DIV;
         end
         S_DIV: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd30) begin
               step_in  = 5'd0;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd15) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            step_in = 5'd0;
            if (k_ff == 2'd2) begin
               state_in = S_OUT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_DIV;
            end
         end
         S_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               tri_in       = !tri_ff;
               job_pop      = tri_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            mag_ff[0] <= da[16] ? 16'(-da) : da[15:0];
            mag_ff[1] <= db[16] ? 16'(-db) : db[15:0];
            mag_ff[2] <= job.spacing;
            neg_ff    <= {1'b0, db[16], da[16]};
         end
         S_SQUARE: begin
            sq_ff[k_ff] <= 32'(mag_ff[k_ff]) * 32'(mag_ff[k_ff]);
         end
         S_SUM: begin
            sum_ff <= 34'(sq_ff[0]) + 34'(sq_ff[1]) + 34'(sq_ff[2]);
            rem_ff <= 35'(sq_ff[0]);
            quo_ff <= '0;
         end
         S_DIV: begin
            rem_ff <= rem_sub << 1;
            quo_ff <= {quo_ff[29:0], qbit};
            if (step_ff == 5'd30) begin
               v_ff   <= {quo_ff[29:0], qbit};
               res_ff <= '0;
               bit_ff <= 32'h4000_0000;
            end
         end
         S_ROOT: begin
            if (take) begin
               v_ff   <= 31'(32'(v_ff) - t);
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         S_ROUND: begin
            comp_ff[k_ff] <= neg_ff[k_ff] ? 16'(-r) : r;
            rem_ff        <= 35'(sq_ff[(k_ff == 2'd2) ? 2'd2 : k_ff + 2'd1]);
            quo_ff        <= '0;
         end
         S_OUT: begin
            if (out_free) begin
               out_ff.nx    <= comp_ff[0];
               out_ff.ny    <= comp_ff[1];
               out_ff.nz    <= comp_ff[2][14:0];
               out_ff.col   <= job.col;
               out_ff.row   <= job.row;
               out_ff.upper <= tri_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tri_ff       <= 1'b0;
         k_ff         <= 2'd0;
         step_ff      <= 5'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tri_ff       <= tri_in;
         k_ff         <= k_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for heightmap_face_normals. Drives height samples
// through the push/full request queue and pops normals with random stalls.
// A local model of the line buffer and the normalizer predicts each normal,
// and every popped result is checked field by field against it. Directed
// tests cover the reset settings, extreme heights and spacings, row length
// clamping, shrinking mid-row and frame restarts.
// A random phase with changing settings follows.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LIMIT_CYCLES = 8000000;
   localparam int SETTLE       = 40;
   localparam int RANDOM_ITEMS = 830;

   typedef struct {
      logic [15:0] nx;
      logic [15:0] ny;
      logic [14:0] nz;
      logic [7:0]  col;
      logic [11:0] row;
      logic        upper;
   } normal_type;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic [15:0]        req_height;
   logic               req_frame_start;
   logic               rsp_empty;
   logic               rsp_pop;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic [14:0]        rsp_normal_z;
   logic [7:0]         rsp_cell_column;
   logic [11:0]        rsp_cell_row;
   logic               rsp_upper_triangle;
   logic               rsp_last_of_run;
   logic               csr_valid;
   logic               csr_ready;
   logic [0:0]         csr_index;
   logic [15:0]        csr_data;

   heightmap_face_normals uut (.*);

   // prediction state
   logic [15:0] spacing_reg;
   logic [8:0]  rowlen_reg;
   logic [15:0] line_buf [256];
   logic [15:0] left_h;
   int unsigned col_cnt;
   int unsigned row_cnt;
   bit          need_frame;

   normal_type  normal_q [$];
   bit          quiet;
   int          fails;
   int          items_sent;
   int          normals_checked;
   int          max_row_seen;
   longint      cycles;
   logic [15:0] prev_h;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] unit_part(longint a, longint unsigned sum);
      longint unsigned mag;
      longint unsigned r;
      mag = (a < 0) ? longint'(-a) : longint'(a);
      r = (int_sqrt((mag * mag << 30) / sum) + 1) >> 1;
      if (a < 0) r = -r;
      return r[15:0];
   endfunction

   function automatic normal_type face_normal(longint a, longint b, longint c,
                                              int unsigned cc, int unsigned rr,
                                              logic upper);
      normal_type n;
      longint unsigned sum;
      logic [15:0] z;
      sum = a * a + b * b + c * c;
      n.nx = unit_part(a, sum);
      n.ny = unit_part(b, sum);
      z = unit_part(c, sum);
      n.nz = z[14:0];
      n.col = cc[7:0];
      n.row = rr[11:0];
      n.upper = upper;
      return n;
   endfunction

   function automatic int unsigned eff_len(logic [8:0] l);
      if (l < 2) return 2;
      if (l > 256) return 256;
      return l;
   endfunction

   task automatic queue_normal(normal_type n);
      normal_q = {normal_q, n};
   endtask

   task automatic predict_sample(logic [15:0] h, logic fs);
      int unsigned len;
      int unsigned c;
      longint z00, z10, z01, z11, s;
      len = eff_len(rowlen_reg);
      if (fs) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      if (col_cnt >= len) begin
         col_cnt = 0;
         if (row_cnt < 4095) row_cnt++;
      end
      c = col_cnt;
      if (c > 0) begin
         if (row_cnt > 0) begin
            z00 = line_buf[c-1];
            z10 = line_buf[c];
            z01 = left_h;
            z11 = h;
            s = (spacing_reg == 0) ? 1 : spacing_reg;
            queue_normal(face_normal(z00 - z10, z10 - z11, s, c - 1, row_cnt - 1, 0));
            queue_normal(face_normal(z01 - z11, z00 - z01, s, c - 1, row_cnt - 1, 1));
            if (row_cnt - 1 > max_row_seen) max_row_seen = row_cnt - 1;
         end
         line_buf[c-1] = left_h;
      end
      if (c + 1 == len) line_buf[c] = h;
      left_h = h;
      col_cnt = c + 1;
      if (col_cnt == len) begin
         col_cnt = 0;
         if (row_cnt < 4095) row_cnt++;
      end
   endtask

   task automatic send_height(logic [15:0] h, logic fs);
      int gap;
      if (!quiet && $urandom_range(3) == 0) begin
         gap = $urandom_range(9, 1);
         repeat (gap) begin
            @(negedge clock);
            req_push <= 1'b0;
         end
      end
      if (need_frame) begin
         fs = 1'b1;
         need_frame = 0;
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_height <= h;
      req_frame_start <= fs;
      do @(posedge clock); while (req_full);
      predict_sample(h, fs);
      items_sent++;
      prev_h = h;
   endtask

   task automatic drain();
      @(negedge clock);
      req_push <= 1'b0;
      while (normal_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [15:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == hmfn_pkg::REG_GRID_SPACING) begin
         spacing_reg = value;
      end else begin
         if (eff_len(value[8:0]) > eff_len(rowlen_reg)) need_frame = 1;
         rowlen_reg = value[8:0];
      end
   endtask

   // result checker
   always @(posedge clock) begin
      normal_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (normal_q.size() == 0) begin
            $error("unexpected normal col %0d row %0d", rsp_cell_column, rsp_cell_row);
            fails++;
         end else begin
            e = normal_q.pop_front();
            normals_checked++;
            if (rsp_normal_x !== e.nx) begin
               $error("normal_x expected %0d got %0d", $signed(e.nx), rsp_normal_x);
               fails++;
            end
            if (rsp_normal_y !== e.ny) begin
               $error("normal_y expected %0d got %0d", $signed(e.ny), rsp_normal_y);
               fails++;
            end
            if (rsp_normal_z !== e.nz) begin
               $error("normal_z expected %0d got %0d", e.nz, rsp_normal_z);
               fails++;
            end
            if (rsp_cell_column !== e.col) begin
               $error("cell_column expected %0d got %0d", e.col, rsp_cell_column);
               fails++;
            end
            if (rsp_cell_row !== e.row) begin
               $error("cell_row expected %0d got %0d", e.row, rsp_cell_row);
               fails++;
            end
            if (rsp_upper_triangle !== e.upper) begin
               $error("upper_triangle expected %0d got %0d", e.upper, rsp_upper_triangle);
               fails++;
            end
            if (rsp_last_of_run !== e.upper) begin
               $error("last_of_run expected %0d got %0d", e.upper, rsp_last_of_run);
               fails++;
            end
         end
      end
   end

   // pop side stalls in bursts
   always @(negedge clock) begin
      int stall;
      if (reset) begin
         rsp_pop <= 1'b0;
         stall = 0;
      end else if (stall > 0) begin
         stall--;
         rsp_pop <= 1'b0;
      end else if (!quiet && $urandom_range(4) == 0) begin
         stall = $urandom_range(9, 1) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   function automatic logic [15:0] pick_height();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         1, 2: return prev_h + 16'($urandom_range(64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_reset_settings();
      for (int i = 0; i < 205; i++) send_height(pick_height(), 1'b0);
   endtask

   task automatic test_extremes();
      write_reg(hmfn_pkg::REG_ROW_LENGTH, 16'd2);
      write_reg(hmfn_pkg::REG_GRID_SPACING, 16'd1);
      send_height(16'h0000, 1'b1);
      send_height(16'hFFFF, 1'b0);
      send_height(16'hFFFF, 1'b0);
      send_height(16'h0000, 1'b0);
      send_height(16'h0000, 1'b0);
      send_height(16'h0000, 1'b0);
      write_reg(hmfn_pkg::REG_GRID_SPACING, 16'hFFFF);
      send_height(16'hFFFF, 1'b0);
      send_height(16'h0000, 1'b0);
      write_reg(hmfn_pkg::REG_GRID_SPACING, 16'h0000);
      send_height(16'h1234, 1'b0);
      send_height(16'hEDCB, 1'b0);
      send_height(16'h5555, 1'b0);
      send_height(16'hAAAA, 1'b0);
   endtask

   task automatic test_length_clamp();
      write_reg(hmfn_pkg::REG_GRID_SPACING, 16'd655);
      write_reg(hmfn_pkg::REG_ROW_LENGTH, 16'd0);
      for (int i = 0; i < 6; i++) send_height(pick_height(), 1'b0);
      write_reg(hmfn_pkg::REG_ROW_LENGTH, 16'd1);
      for (int i = 0; i < 4; i++) send_height(pick_height(), 1'b0);
      write_reg(hmfn_pkg::REG_ROW_LENGTH, 16'd511);
      for (int i = 0; i < 260; i++) send_height(pick_height(), 1'b0);
      write_reg(hmfn_pkg::REG_ROW_LENGTH, 16'd257);
      for (int i = 0; i < 4; i++) send_height(pick_height(), 1'b0);
   endtask

   task automatic test_shrink_and_restart();
      write_reg(hmfn_pkg::REG_ROW_LENGTH, 16'd6);
      send_height(pick_height(), 1'b1);
      for (int i = 0; i < 9; i++) send_height(pick_height(), 1'b0);
      write_reg(hmfn_pkg::REG_ROW_LENGTH, 16'd3);
      for (int i = 0; i < 7; i++) send_height(pick_height(), 1'b0);
      send_height(pick_height(), 1'b1);
      for (int i = 0; i < 4; i++) send_height(pick_height(), 1'b0);
      send_height(pick_height(), 1'b1);
      for (int i = 0; i < 5; i++) send_height(pick_height(), 1'b0);
   endtask

   task automatic test_random();
      int n;
      n = 0;
      while (n < RANDOM_ITEMS) begin
         if ($urandom_range(2) == 0)
            write_reg(hmfn_pkg::REG_GRID_SPACING, 16'($urandom));
         if ($urandom_range(1) == 0)
            write_reg(hmfn_pkg::REG_ROW_LENGTH,
                      $urandom_range(7) == 0 ? 16'($urandom_range(511))
                                             : 16'($urandom_range(12, 2)));
         if (n > RANDOM_ITEMS - 150) quiet = 1;
         for (int i = 0; i < 100 && n < RANDOM_ITEMS; i++) begin
            send_height(pick_height(), $urandom_range(150) == 0);
            n++;
         end
         if ($urandom_range(3) == 0) drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_height = '0;
      req_frame_start = 1'b0;
      csr_valid = 1'b0;
      csr_index = hmfn_pkg::REG_GRID_SPACING;
      csr_data = '0;
      spacing_reg = hmfn_pkg::SPACING_RESET;
      rowlen_reg = hmfn_pkg::ROW_LENGTH_RESET;
      col_cnt = 0;
      row_cnt = 0;
      left_h = '0;
      prev_h = '0;
      for (int i = 0; i < 256; i++) line_buf[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_settings();
      test_extremes();
      test_length_clamp();
      test_shrink_and_restart();
      test_random();

      drain();
      $display("ran %0d height samples, checked %0d normals, highest cell row %0d",
               items_sent, normals_checked, max_row_seen);
      $display("covered spacing 0/1/max, row length clamping, mid-row shrink, restarts");
      if (fails == 0 && normal_q.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
